[rtl/core/arw_pkg.sv]
// ----------------------------------------------------------------------------
// Arrow rasterizer package
// Shared constants, direction tables, the configuration record and the
// width helpers used by the front end, the queue and the drawing engine.
// ----------------------------------------------------------------------------
package arw_pkg;

   localparam int SIZE_BITS_DEF  = 12;
   localparam int COORD_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;

   localparam int PIX_BITS    = 12;
   localparam int SCREEN_BITS = 13;
   localparam int ORIGIN_BITS = 12;
   localparam int OUT_TDATA_W = 2 * PIX_BITS;

   localparam logic [SCREEN_BITS-1:0] SCREEN_MAX = 13'd4096;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = SCREEN_BITS;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_X      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_Y      = 2'd3;

   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 13'd256;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 13'd224;
   localparam logic [ORIGIN_BITS-1:0] ORIGIN_RST        = 12'd0;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   localparam logic signed [1:0] K_NEG  = 2'sb11;
   localparam logic signed [1:0] K_ZERO = 2'sb00;
   localparam logic signed [1:0] K_POS  = 2'sb01;

   localparam logic signed [1:0] STEP_X [8] =
      '{K_NEG, K_NEG, K_ZERO, K_POS, K_POS, K_POS, K_ZERO, K_NEG};
   localparam logic signed [1:0] STEP_Y [8] =
      '{K_ZERO, K_POS, K_POS, K_POS, K_ZERO, K_NEG, K_NEG, K_NEG};
   localparam logic signed [1:0] NEG_X [8] =
      '{K_ZERO, K_ZERO, K_POS, K_POS, K_ZERO, K_ZERO, K_NEG, K_NEG};
   localparam logic signed [1:0] NEG_Y [8] =
      '{K_POS, K_POS, K_ZERO, K_ZERO, K_NEG, K_NEG, K_ZERO, K_ZERO};
   localparam logic signed [1:0] POS_X [8] =
      '{K_ZERO, K_POS, K_POS, K_ZERO, K_ZERO, K_NEG, K_NEG, K_ZERO};
   localparam logic signed [1:0] POS_Y [8] =
      '{K_POS, K_ZERO, K_ZERO, K_NEG, K_NEG, K_ZERO, K_ZERO, K_POS};

   typedef struct packed {
      logic [SCREEN_BITS-1:0] screen_width;
      logic [SCREEN_BITS-1:0] screen_height;
      logic [ORIGIN_BITS-1:0] origin_x;
      logic [ORIGIN_BITS-1:0] origin_y;
   } cfg_type;

   function automatic int base_width(input int c);
      return ((c > ORIGIN_BITS + 1) ? c : ORIGIN_BITS + 1) + 1;
   endfunction

   function automatic int pix_width(input int s, input int c);
      int m;
      m = (c > ORIGIN_BITS + 1) ? c : ORIGIN_BITS + 1;
      if (s + 2 > m) begin
         m = s + 2;
      end
      return m + 3;
   endfunction

   function automatic int entry_width(input int s, input int c);
      return 1 + 2 * base_width(c) + 2 * s + 4 + 6 * (s + 1);
   endfunction

   function automatic int in_tdata_width(input int s, input int c);
      return ((2 * c + 4 * s + 4 + 7) / 8) * 8;
   endfunction

endpackage

[rtl/core/arrow_pixel_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// Arrow pixel rasterizer
// Draws an arrow in one of eight directions as a stream of candidate pixels.
// ----------------------------------------------------------------------------
// A start transaction loads the tip, the sizes, the heading and the fill mode
// and returns nothing; each step transaction returns one pixel with a valid
// flag in tuser and the end-of-arrow mark in tlast. One transaction is taken
// per clock cycle while the queue has room: the engine handles a start or a
// step as it takes it, and its result is registered. An input transaction
// passes through the queue and then the engine into the result register, and
// a step waits in the queue while an earlier result has not been taken. A
// four-entry queue sits between the input decoder and the engine, and the input
// side only stalls when that queue is full because results are not being taken.
module arrow_pixel_rasterizer_top #(
   parameter int SIZE_BITS  = arw_pkg::SIZE_BITS_DEF,
   parameter int COORD_BITS = arw_pkg::COORD_BITS_DEF
) (
   input  logic                                                      clock,
   input  logic                                                      reset,
   input  logic                                                      req_tvalid,
   output logic                                                      req_tready,
   // tip_x, tip_y, shaft_length, shaft_width, head_width, head_thickness,
   // heading, filled_head, zero padding
   input  logic [arw_pkg::in_tdata_width(SIZE_BITS, COORD_BITS)-1:0] req_tdata,
   // action
   input  logic                                                      req_tuser,
   output logic                                                      rsp_tvalid,
   input  logic                                                      rsp_tready,
   // pixel_x, pixel_y
   output logic [arw_pkg::OUT_TDATA_W-1:0]                           rsp_tdata,
   // pixel_valid
   output logic                                                      rsp_tuser,
   output logic                                                      rsp_tlast,
   input  logic                                                      csr_we,
   input  logic [arw_pkg::CSR_ADDR_W-1:0]                            csr_addr,
   input  logic [arw_pkg::CSR_DATA_W-1:0]                            csr_wdata
);
   import arw_pkg::*;

   localparam int EW = entry_width(SIZE_BITS, COORD_BITS);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic [EW-1:0]    front_data;
   logic             ent_valid;
   logic             ent_ready;
   logic [EW-1:0]    ent_data;
   logic [SCREEN_BITS-1:0] sw_clip;
   logic [SCREEN_BITS-1:0] sh_clip;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SCREEN_WIDTH: begin
               cfg_in.screen_width = csr_wdata;
            end
            CSR_SCREEN_HEIGHT: begin
               cfg_in.screen_height = csr_wdata;
            end
            CSR_ORIGIN_X: begin
               cfg_in.origin_x = csr_wdata[ORIGIN_BITS-1:0];
            end
            CSR_ORIGIN_Y: begin
               cfg_in.origin_y = csr_wdata[ORIGIN_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RST;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RST;
         cfg_ff.origin_x      <= ORIGIN_RST;
         cfg_ff.origin_y      <= ORIGIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   arw_front #(
      .SIZE_BITS  (SIZE_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg_ff),
      .ent_data  (front_data)
   );

   arw_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (front_data),
      .rd_valid (ent_valid),
      .rd_ready (ent_ready),
      .rd_data  (ent_data)
   );

   arw_back #(
      .SIZE_BITS  (SIZE_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .ent_valid  (ent_valid),
      .ent_ready  (ent_ready),
      .ent_data   (ent_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign sw_clip = (cfg_ff.screen_width > SCREEN_MAX) ? SCREEN_MAX : cfg_ff.screen_width;
   assign sh_clip = (cfg_ff.screen_height > SCREEN_MAX) ? SCREEN_MAX : cfg_ff.screen_height;

   a_pixel_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (({1'b0, rsp_tdata[PIX_BITS-1:0]} < sw_clip)
          && ({1'b0, rsp_tdata[OUT_TDATA_W-1:PIX_BITS]} < sh_clip)))
      else $error("drawn pixel lies outside the clipped screen");

   a_invalid_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("invalid pixel carries non-zero coordinates");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (ent_valid && rsp_tvalid))
      else $error("input stalled with no result waiting at the output");

endmodule

[rtl/core/arw_front.sv]
// ----------------------------------------------------------------------------
// Arrow rasterizer front end
// Unpacks an incoming transaction, adds the frame origin to the tip and
// works out the shaft and head bands and the row range for a start.
// ----------------------------------------------------------------------------
module arw_front #(
   parameter int SIZE_BITS  = arw_pkg::SIZE_BITS_DEF,
   parameter int COORD_BITS = arw_pkg::COORD_BITS_DEF
) (
   input  logic [arw_pkg::in_tdata_width(SIZE_BITS, COORD_BITS)-1:0] req_tdata,
   input  logic                                                      req_tuser,
   input  arw_pkg::cfg_type                                          cfg,
   output logic [arw_pkg::entry_width(SIZE_BITS, COORD_BITS)-1:0]    ent_data
);
   import arw_pkg::*;

   localparam int S  = SIZE_BITS;
   localparam int C  = COORD_BITS;
   localparam int BW = base_width(C);

   logic signed [C-1:0]  tip_x;
   logic signed [C-1:0]  tip_y;
   logic [S-1:0]         len;
   logic [S-1:0]         shaft_w;
   logic [S-1:0]         head_w;
   logic [S-1:0]         head_t;
   logic [2:0]           heading;
   logic                 filled;
   logic signed [BW-1:0] base_x;
   logic signed [BW-1:0] base_y;
   logic signed [S:0]    cmin;
   logic signed [S:0]    cmax;
   logic signed [S:0]    hmin;
   logic signed [S:0]    hmax;
   logic signed [S:0]    row_lo;
   logic signed [S:0]    row_hi;
   logic [S:0]           shaft_sum;
   logic [S:0]           head_sum;

   assign tip_x   = req_tdata[C-1:0];
   assign tip_y   = req_tdata[2*C-1:C];
   assign len     = req_tdata[2*C+S-1:2*C];
   assign shaft_w = req_tdata[2*C+2*S-1:2*C+S];
   assign head_w  = req_tdata[2*C+3*S-1:2*C+2*S];
   assign head_t  = req_tdata[2*C+4*S-1:2*C+3*S];
   assign heading = req_tdata[2*C+4*S+2:2*C+4*S];
   assign filled  = req_tdata[2*C+4*S+3];

   assign base_x = $signed({{(BW-C){tip_x[C-1]}}, tip_x})
                 + $signed({{(BW-ORIGIN_BITS){1'b0}}, cfg.origin_x});
   assign base_y = $signed({{(BW-C){tip_y[C-1]}}, tip_y})
                 + $signed({{(BW-ORIGIN_BITS){1'b0}}, cfg.origin_y});

   assign shaft_sum = {1'b0, shaft_w} + (S+1)'(1);
   assign head_sum  = {1'b0, head_w} + (S+1)'(1);

   assign cmin = -$signed({2'b00, shaft_w[S-1:1]});
   assign hmin = -$signed({2'b00, head_w[S-1:1]});
   assign cmax = $signed({1'b0, shaft_sum[S:1]});
   assign hmax = $signed({1'b0, head_sum[S:1]});

   assign row_lo = (cmin < hmin) ? cmin : hmin;
   assign row_hi = (cmax > hmax) ? cmax : hmax;

   assign ent_data = {row_hi, row_lo, hmax, hmin, cmax, cmin, filled, heading,
                      head_t, len, base_y, base_x, (req_tuser == ACT_STEP)};

endmodule

[rtl/core/arw_queue.sv]
// ----------------------------------------------------------------------------
// Arrow rasterizer queue
// Small first-in first-out store that decouples the front end from the
// drawing engine.
// ----------------------------------------------------------------------------
module arw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = arw_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   import arw_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    rd_ptr_in;
   logic [NW-1:0]    count_ff;
   logic [NW-1:0]    count_in;
   logic             push;
   logic             pop;

   assign wr_ready = (count_ff != NW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/core/arw_back.sv]
// ----------------------------------------------------------------------------
// Arrow rasterizer drawing engine
// Holds the arrow being drawn, walks its rows and columns one step per
// transaction, clips each pixel and registers the result.
// ----------------------------------------------------------------------------
module arw_back #(
   parameter int SIZE_BITS  = arw_pkg::SIZE_BITS_DEF,
   parameter int COORD_BITS = arw_pkg::COORD_BITS_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  arw_pkg::cfg_type                                       cfg,
   input  logic                                                   ent_valid,
   output logic                                                   ent_ready,
   input  logic [arw_pkg::entry_width(SIZE_BITS, COORD_BITS)-1:0] ent_data,
   output logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   output logic [arw_pkg::OUT_TDATA_W-1:0]                        rsp_tdata,
   output logic                                                   rsp_tuser,
   output logic                                                   rsp_tlast
);
   import arw_pkg::*;

   localparam int S  = SIZE_BITS;
   localparam int C  = COORD_BITS;
   localparam int BW = base_width(C);
   localparam int PW = pix_width(S, C);
   localparam int CW = S + 2;

   logic                 e_is_step;
   logic signed [BW-1:0] e_base_x;
   logic signed [BW-1:0] e_base_y;
   logic [S-1:0]         e_len;
   logic [S-1:0]         e_ht;
   logic [2:0]           e_heading;
   logic                 e_filled;
   logic signed [S:0]    e_cmin;
   logic signed [S:0]    e_cmax;
   logic signed [S:0]    e_hmin;
   logic signed [S:0]    e_hmax;
   logic signed [S:0]    e_row_lo;
   logic signed [S:0]    e_row_hi;

   logic signed [BW-1:0] base_x_ff, base_x_in;
   logic signed [BW-1:0] base_y_ff, base_y_in;
   logic [S-1:0]         len_ff, len_in;
   logic [S-1:0]         ht_ff, ht_in;
   logic [2:0]           heading_ff, heading_in;
   logic                 filled_ff, filled_in;
   logic signed [S:0]    cmin_ff, cmin_in;
   logic signed [S:0]    cmax_ff, cmax_in;
   logic signed [S:0]    hmin_ff, hmin_in;
   logic signed [S:0]    hmax_ff, hmax_in;
   logic signed [S:0]    row_offset_ff, row_offset_in;
   logic signed [S:0]    row_limit_ff, row_limit_in;
   logic [CW-1:0]        column_ff, column_in;
   logic [CW-1:0]        column_limit_ff, column_limit_in;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pix_ff, rsp_pix_in;
   logic [PIX_BITS-1:0]  rsp_x_ff, rsp_x_in;
   logic [PIX_BITS-1:0]  rsp_y_ff, rsp_y_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 take;
   logic                 rows_left;
   logic                 has_pix;
   logic [CW-1:0]        col_next;
   logic                 row_end;
   logic signed [S:0]    row_next;
   logic                 last_row;
   logic [2*CW-1:0]      span;
   logic signed [PW-1:0] o_ext;
   logic signed [PW-1:0] d_ext;
   logic signed [PW-1:0] px;
   logic signed [PW-1:0] py;
   logic signed [1:0]    side_x;
   logic signed [1:0]    side_y;
   logic [SCREEN_BITS-1:0] sw_clip;
   logic [SCREEN_BITS-1:0] sh_clip;
   logic                 on_screen;

   function automatic logic signed [PW-1:0] scale_unit(input logic signed [1:0] k,
                                                        input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      r = '0;
      if (k == K_POS) begin
         r = v;
      end else if (k == K_NEG) begin
         r = -v;
      end
      return r;
   endfunction

   function automatic logic [2*CW-1:0] row_span(input logic signed [S:0] o,
                                                input logic [S-1:0] len,
                                                input logic [S-1:0] ht,
                                                input logic odd,
                                                input logic filled,
                                                input logic signed [S:0] cmin,
                                                input logic signed [S:0] cmax,
                                                input logic signed [S:0] hmin,
                                                input logic signed [S:0] hmax);
      logic [S:0]    mag;
      logic [CW-1:0] minc;
      logic [CW-1:0] maxc;
      logic [CW-1:0] hm;
      logic [CW-1:0] e;
      mag  = o[S] ? -o : o;
      minc = {1'b0, mag};
      hm   = {1'b0, hmax};
      maxc = '0;
      if (o >= cmin && o < cmax) begin
         maxc = {2'b00, len};
      end
      if (o >= hmin && o < hmax) begin
         if (filled) begin
            e = odd ? minc + ((hm - minc) >> 1) + CW'(1) : hm;
         end else begin
            e = minc + {2'b00, ht};
         end
         if (e > maxc) begin
            maxc = e;
         end
      end
      return {minc, maxc};
   endfunction

   assign {e_row_hi, e_row_lo, e_hmax, e_hmin, e_cmax, e_cmin, e_filled, e_heading,
           e_ht, e_len, e_base_y, e_base_x, e_is_step} = ent_data;

   assign ent_ready = !e_is_step || !rsp_valid_ff || rsp_tready;
   assign take      = ent_valid && ent_ready;

   assign rows_left = row_offset_ff < row_limit_ff;
   assign has_pix   = column_ff < column_limit_ff;
   assign col_next  = has_pix ? column_ff + CW'(1) : column_limit_ff;
   assign row_end   = col_next >= column_limit_ff;
   assign row_next  = row_offset_ff + (S+1)'(1);
   assign last_row  = row_next >= row_limit_ff;

   assign span = e_is_step
      ? row_span(row_next, len_ff, ht_ff, heading_ff[0], filled_ff,
                 cmin_ff, cmax_ff, hmin_ff, hmax_ff)
      : row_span(e_row_lo, e_len, e_ht, e_heading[0], e_filled,
                 e_cmin, e_cmax, e_hmin, e_hmax);

   assign o_ext  = $signed({{(PW-S-1){row_offset_ff[S]}}, row_offset_ff});
   assign d_ext  = $signed({{(PW-CW){1'b0}}, column_ff});
   assign side_x = row_offset_ff[S] ? NEG_X[heading_ff] : POS_X[heading_ff];
   assign side_y = row_offset_ff[S] ? NEG_Y[heading_ff] : POS_Y[heading_ff];

   assign px = $signed({{(PW-BW){base_x_ff[BW-1]}}, base_x_ff})
             + scale_unit(side_x, o_ext) + scale_unit(STEP_X[heading_ff], d_ext);
   assign py = $signed({{(PW-BW){base_y_ff[BW-1]}}, base_y_ff})
             + scale_unit(side_y, o_ext) + scale_unit(STEP_Y[heading_ff], d_ext);

   assign sw_clip = (cfg.screen_width > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_width;
   assign sh_clip = (cfg.screen_height > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_height;

   assign on_screen = !px[PW-1] && !py[PW-1]
                   && (px < $signed({{(PW-SCREEN_BITS){1'b0}}, sw_clip}))
                   && (py < $signed({{(PW-SCREEN_BITS){1'b0}}, sh_clip}));

   always_comb begin
      base_x_in       = base_x_ff;
      base_y_in       = base_y_ff;
      len_in          = len_ff;
      ht_in           = ht_ff;
      heading_in      = heading_ff;
      filled_in       = filled_ff;
      cmin_in         = cmin_ff;
      cmax_in         = cmax_ff;
      hmin_in         = hmin_ff;
      hmax_in         = hmax_ff;
      row_offset_in   = row_offset_ff;
      row_limit_in    = row_limit_ff;
      column_in       = column_ff;
      column_limit_in = column_limit_ff;
      busy_in         = busy_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_pix_in      = rsp_pix_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_done_in     = rsp_done_ff;
      if (take) begin
         if (!e_is_step) begin
            base_x_in                    = e_base_x;
            base_y_in                    = e_base_y;
            len_in                       = e_len;
            ht_in                        = e_ht;
            heading_in                   = e_heading;
            filled_in                    = e_filled;
            cmin_in                      = e_cmin;
            cmax_in                      = e_cmax;
            hmin_in                      = e_hmin;
            hmax_in                      = e_hmax;
            row_offset_in                = e_row_lo;
            row_limit_in                 = e_row_hi;
            {column_in, column_limit_in} = span;
            busy_in                      = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_pix_in   = 1'b0;
            rsp_x_in     = '0;
            rsp_y_in     = '0;
            rsp_done_in  = 1'b0;
            if (!busy_ff) begin
               rsp_done_in = 1'b1;
            end else if (!rows_left) begin
               busy_in     = 1'b0;
               rsp_done_in = 1'b1;
            end else begin
               if (has_pix && on_screen) begin
                  rsp_pix_in = 1'b1;
                  rsp_x_in   = px[PIX_BITS-1:0];
                  rsp_y_in   = py[PIX_BITS-1:0];
               end
               column_in = col_next;
               if (row_end) begin
                  row_offset_in = row_next;
                  if (last_row) begin
                     busy_in     = 1'b0;
                     rsp_done_in = 1'b1;
                  end else begin
                     {column_in, column_limit_in} = span;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_x_ff       <= base_x_in;
      base_y_ff       <= base_y_in;
      len_ff          <= len_in;
      ht_ff           <= ht_in;
      heading_ff      <= heading_in;
      filled_ff       <= filled_in;
      cmin_ff         <= cmin_in;
      cmax_ff         <= cmax_in;
      hmin_ff         <= hmin_in;
      hmax_ff         <= hmax_in;
      row_offset_ff   <= row_offset_in;
      row_limit_ff    <= row_limit_in;
      column_ff       <= column_in;
      column_limit_ff <= column_limit_in;
      rsp_pix_ff      <= rsp_pix_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_pix_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule
